// File: rtl/gls_pkg.sv
`default_nettype none

package gls_pkg;

    // Fixed datapath widths
    localparam int COORD_W = 16;            // point coordinate
    localparam int DELTA_W = 17;            // segment delta
    localparam int WIDE_W  = 20;            // grid boundary, cell, multiplier operand
    localparam int PROD_W  = 40;            // product and numerator
    localparam int DIV_NW  = 40;            // divider dividend
    localparam int DIV_DW  = 20;            // divider divisor
    localparam int GRID_W  = 7;             // grid_divisions register
    localparam int CFG_W   = 7;             // configuration write data

    // Configuration register indexes
    localparam logic CFG_IDX_GRID = 1'b0;
    localparam logic CFG_IDX_RING = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FIRST_EMIT,
        ST_PASS_IN,
        ST_PASS_RING,
        ST_PASS_FIRST,
        ST_CELL_START,
        ST_CELL_WAIT,
        ST_SEG_LOAD,
        ST_BX_DIV,
        ST_BX_WAIT,
        ST_BX_MUL,
        ST_BY_DIV,
        ST_BY_WAIT,
        ST_BY_MUL,
        ST_CHECK,
        ST_PX_MUL,
        ST_PY_MUL,
        ST_CMP,
        ST_N1_MUL,
        ST_N2_MUL,
        ST_RND_DIV,
        ST_RND_WAIT,
        ST_CROSS_EMIT,
        ST_END_EMIT,
        ST_SEG_DONE,
        ST_FINISH,
        ST_OUT_READ,
        ST_OUT_SHOW
    } state_t;

    typedef enum logic [1:0] {
        EM_FIRST,
        EM_INPUT,
        EM_CROSS,
        EM_END
    } emit_sel_t;

    typedef enum logic [1:0] {
        DV_CELL,
        DV_BX,
        DV_BY,
        DV_RND
    } div_sel_t;

    typedef enum logic [2:0] {
        MU_NONE,
        MU_BX,
        MU_BY,
        MU_PX,
        MU_PY,
        MU_N1,
        MU_N2
    } mul_op_t;

    typedef enum logic {
        SEG_PREV_IN,
        SEG_IN_FIRST
    } seg_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      latch_in;
        logic      first_only;
        logic      clr_cnt;
        logic      emit_en;
        emit_sel_t emit_sel;
        logic      dedupe;
        logic      div_start;
        div_sel_t  div_sel;
        logic      cell_load;
        logic      seg_load;
        seg_sel_t  seg_sel;
        mul_op_t   mul_op;
        logic      take_single;
        logic      take_cmp;
        logic      advance;
        logic      finish;
        logic      rd_en;
        logic      rd_next;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic seen0;
        logic seen1;
        logic pass;
        logic zero_len;
        logic vx;
        logic vy;
        logic div_busy;
        logic ring_close;
        logic cnt_zero;
        logic rd_last;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/gls_ram.sv
`default_nettype none

module gls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/gls_divider.sv
`default_nettype none

module gls_divider
    import gls_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIV_NW-1:0] dividend,
    input  wire logic [DIV_DW-1:0] divisor,
    output logic                   busy,
    output logic      [DIV_NW-1:0] quotient,
    output logic      [DIV_DW-1:0] remainder
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] dvs_reg, dvs_next;
    logic [DIV_DW:0]   shifted;
    logic              ge;

    // One restoring step per cycle, MSB first
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_NW-1]};
        ge        = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_NW);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIV_DW'(shifted - {1'b0, dvs_reg}) : shifted[DIV_DW-1:0];
            quo_next = {quo_reg[DIV_NW-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: rtl/gls_datapath.sv
`default_nettype none

module gls_datapath
    import gls_pkg::*;
#(
    parameter int TILE_EXTENT = 8192,
    parameter int MAX_RUN     = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cmd_t                      cmd,
    output status_t                        st,
    input  wire logic signed [COORD_W-1:0] point_x,
    input  wire logic signed [COORD_W-1:0] point_y,
    input  wire logic                      line_end,
    input  wire logic                      cfg_write,
    input  wire logic                      cfg_index,
    input  wire logic        [CFG_W-1:0]   cfg_data,
    output logic signed      [COORD_W-1:0] out_x,
    output logic signed      [COORD_W-1:0] out_y,
    output logic                           run_last,
    output logic                           truncated
);

    localparam int ADDR_W = $clog2(MAX_RUN);
    localparam int CNT_W  = $clog2(MAX_RUN + 1);

    // Configuration
    logic [GRID_W-1:0] gd_reg;
    logic              ring_reg;

    // Line state
    logic signed [COORD_W-1:0] in_x_reg, in_y_reg;
    logic                      in_end_reg;
    logic signed [COORD_W-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic signed [COORD_W-1:0] emit_x_reg, emit_y_reg;
    logic [1:0]                seen_reg;

    // Segment walk
    logic        [WIDE_W-1:0]  cell_reg;
    logic signed [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic signed [WIDE_W-1:0]  bx_reg, by_reg;
    logic        [PROD_W-1:0]  px_reg, py_reg;
    logic signed [PROD_W-1:0]  num_reg;
    logic                      take_x_reg, tie_reg;

    // Result buffer
    logic [CNT_W-1:0]  cnt_reg;
    logic              over_reg;
    logic [ADDR_W-1:0] rd_idx_reg;

    logic              div_busy;
    logic [DIV_NW-1:0] div_q;
    logic [DIV_DW-1:0] div_r;
    logic [DIV_NW-1:0] div_n;
    logic [DIV_DW-1:0] div_d;

    logic signed [WIDE_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [WIDE_W-1:0]  x0_w, y0_w, x1_w, y1_w, dx_w, dy_w;
    logic signed [WIDE_W-1:0]  bx_off, by_off, sx, sy;
    logic signed [DELTA_W-1:0] den;
    logic        [DELTA_W-1:0] den_abs;
    logic        [PROD_W-1:0]  num_abs;
    logic        [COORD_W-1:0] rq;
    logic signed [COORD_W-1:0] cand_x, cand_y;
    logic signed [COORD_W-1:0] seg_x0, seg_y0, seg_x1, seg_y1;
    logic                      skip;
    logic                      cnt_full;
    logic                      ram_we;
    logic [2*COORD_W-1:0]      ram_rdata;

    // First grid index past c in the walk direction, times one cell later
    function automatic logic signed [WIDE_W-1:0] grid_start(
        input logic                      dpos,
        input logic signed [COORD_W-1:0] c,
        input logic        [WIDE_W-1:0]  q,
        input logic                      rnz
    );
        logic signed [WIDE_W-1:0] qs;
        logic signed [WIDE_W-1:0] r1;
        logic signed [WIDE_W-1:0] one;
        begin
            qs  = signed'(q);
            r1  = signed'({{(WIDE_W-1){1'b0}}, rnz});
            one = signed'(WIDE_W'(1));
            if (dpos)
            begin
                grid_start = (c >= 0) ? qs + one : -qs - r1 + one;
            end
            else
            begin
                grid_start = (c > 0) ? qs + r1 - one : -qs - one;
            end
        end
    endfunction

    assign x0_w   = WIDE_W'(x0_reg);
    assign y0_w   = WIDE_W'(y0_reg);
    assign x1_w   = WIDE_W'(x1_reg);
    assign y1_w   = WIDE_W'(y1_reg);
    assign dx_w   = WIDE_W'(dx_reg);
    assign dy_w   = WIDE_W'(dy_reg);
    assign bx_off = bx_reg - x0_w;
    assign by_off = by_reg - y0_w;
    assign sx     = (dx_reg > 0) ? signed'(cell_reg) : -signed'(cell_reg);
    assign sy     = (dy_reg > 0) ? signed'(cell_reg) : -signed'(cell_reg);

    // Rounding divide operands: (2|num| + |den|) / (2|den|)
    assign den     = take_x_reg ? dx_reg : dy_reg;
    assign den_abs = (den < 0) ? DELTA_W'(-den) : DELTA_W'(den);
    assign num_abs = (num_reg < 0) ? PROD_W'(-num_reg) : PROD_W'(num_reg);
    assign rq      = (num_reg[PROD_W-1] ^ den[DELTA_W-1]) ? COORD_W'(-div_q[COORD_W-1:0])
                                                          : div_q[COORD_W-1:0];

    always_comb
    begin
        div_n = '0;
        div_d = '0;
        case (cmd.div_sel)
            DV_CELL:
            begin
                div_n = DIV_NW'(TILE_EXTENT);
                div_d = DIV_DW'(gd_reg);
            end
            DV_BX:
            begin
                div_n = DIV_NW'((x0_w < 0) ? -x0_w : x0_w);
                div_d = cell_reg;
            end
            DV_BY:
            begin
                div_n = DIV_NW'((y0_w < 0) ? -y0_w : y0_w);
                div_d = cell_reg;
            end
            default:
            begin
                div_n = (num_abs << 1) + DIV_NW'(den_abs);
                div_d = DIV_DW'({den_abs, 1'b0});
            end
        endcase
    end

    gls_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Shared multiplier, registered into its target below
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MU_BX:
            begin
                mul_a = grid_start(dx_reg > 0, x0_reg, div_q[WIDE_W-1:0], div_r != '0);
                mul_b = signed'(cell_reg);
            end
            MU_BY:
            begin
                mul_a = grid_start(dy_reg > 0, y0_reg, div_q[WIDE_W-1:0], div_r != '0);
                mul_b = signed'(cell_reg);
            end
            MU_PX:
            begin
                mul_a = (bx_off < 0) ? -bx_off : bx_off;
                mul_b = (dy_w < 0) ? -dy_w : dy_w;
            end
            MU_PY:
            begin
                mul_a = (by_off < 0) ? -by_off : by_off;
                mul_b = (dx_w < 0) ? -dx_w : dx_w;
            end
            MU_N1:
            begin
                mul_a = take_x_reg ? y0_w : x0_w;
                mul_b = take_x_reg ? dx_w : dy_w;
            end
            MU_N2:
            begin
                mul_a = take_x_reg ? dy_w : dx_w;
                mul_b = take_x_reg ? bx_off : by_off;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Segment end points
    always_comb
    begin
        if (cmd.seg_sel == SEG_IN_FIRST)
        begin
            seg_x0 = in_x_reg;
            seg_y0 = in_y_reg;
            seg_x1 = first_x_reg;
            seg_y1 = first_y_reg;
        end
        else
        begin
            seg_x0 = prev_x_reg;
            seg_y0 = prev_y_reg;
            seg_x1 = in_x_reg;
            seg_y1 = in_y_reg;
        end
    end

    // Emit candidate and duplicate check
    always_comb
    begin
        case (cmd.emit_sel)
            EM_FIRST:
            begin
                cand_x = first_x_reg;
                cand_y = first_y_reg;
            end
            EM_INPUT:
            begin
                cand_x = in_x_reg;
                cand_y = in_y_reg;
            end
            EM_CROSS:
            begin
                cand_x = take_x_reg ? bx_reg[COORD_W-1:0] : signed'(rq);
                cand_y = take_x_reg ? signed'(rq) : by_reg[COORD_W-1:0];
            end
            default:
            begin
                cand_x = x1_reg;
                cand_y = y1_reg;
            end
        endcase
    end

    assign skip     = cmd.dedupe && (cand_x == emit_x_reg) && (cand_y == emit_y_reg);
    assign cnt_full = (cnt_reg == CNT_W'(MAX_RUN));
    assign ram_we   = cmd.emit_en && !skip && !cnt_full;

    gls_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_RUN)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata ({cand_x, cand_y}),
        .re    (cmd.rd_en),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Control and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gd_reg      <= GRID_W'(1);
            ring_reg    <= 1'b0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            emit_x_reg  <= '0;
            emit_y_reg  <= '0;
            seen_reg    <= '0;
            cnt_reg     <= '0;
            over_reg    <= 1'b0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_IDX_GRID: gd_reg   <= cfg_data[GRID_W-1:0];
                    CFG_IDX_RING: ring_reg <= cfg_data[0];
                    default:      ring_reg <= ring_reg;
                endcase
            end
            if (cmd.first_only)
            begin
                first_x_reg <= in_x_reg;
                first_y_reg <= in_y_reg;
                prev_x_reg  <= in_x_reg;
                prev_y_reg  <= in_y_reg;
                seen_reg    <= in_end_reg ? 2'd0 : 2'd1;
            end
            if (cmd.finish)
            begin
                prev_x_reg <= in_x_reg;
                prev_y_reg <= in_y_reg;
                seen_reg   <= in_end_reg ? 2'd0 : 2'd2;
            end
            if (cmd.clr_cnt)
            begin
                cnt_reg    <= '0;
                over_reg   <= 1'b0;
                rd_idx_reg <= '0;
            end
            else if (cmd.emit_en && !skip)
            begin
                emit_x_reg <= cand_x;
                emit_y_reg <= cand_y;
                if (cnt_full)
                begin
                    over_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            if (cmd.rd_next)
            begin
                rd_idx_reg <= rd_idx_reg + ADDR_W'(1);
            end
        end
    end

    // Walk payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_x_reg   <= point_x;
            in_y_reg   <= point_y;
            in_end_reg <= line_end;
        end
        if (cmd.cell_load)
        begin
            cell_reg <= div_q[WIDE_W-1:0];
        end
        if (cmd.seg_load)
        begin
            x0_reg <= seg_x0;
            y0_reg <= seg_y0;
            x1_reg <= seg_x1;
            y1_reg <= seg_y1;
            dx_reg <= DELTA_W'(seg_x1) - DELTA_W'(seg_x0);
            dy_reg <= DELTA_W'(seg_y1) - DELTA_W'(seg_y0);
        end
        case (cmd.mul_op)
            MU_BX:   bx_reg  <= prod[WIDE_W-1:0];
            MU_BY:   by_reg  <= prod[WIDE_W-1:0];
            MU_PX:   px_reg  <= prod;
            MU_PY:   py_reg  <= prod;
            MU_N1:   num_reg <= prod;
            MU_N2:   num_reg <= num_reg + prod;
            default: num_reg <= num_reg;
        endcase
        if (cmd.take_single)
        begin
            take_x_reg <= st.vx;
            tie_reg    <= 1'b0;
        end
        if (cmd.take_cmp)
        begin
            take_x_reg <= px_reg < py_reg;
            tie_reg    <= px_reg == py_reg;
        end
        if (cmd.advance)
        begin
            if (take_x_reg)
            begin
                bx_reg <= bx_reg + sx;
            end
            else
            begin
                by_reg <= by_reg + sy;
                if (tie_reg)
                begin
                    bx_reg <= bx_reg + sx;
                end
            end
        end
    end

    // Status toward the controller
    always_comb
    begin
        st.seen0      = (seen_reg == 2'd0);
        st.seen1      = (seen_reg == 2'd1);
        st.pass       = (gd_reg < GRID_W'(2));
        st.zero_len   = (dx_reg == '0) && (dy_reg == '0);
        st.vx         = (dx_reg != '0) && ((dx_reg > 0) ? (bx_reg < x1_w) : (bx_reg > x1_w));
        st.vy         = (dy_reg != '0) && ((dy_reg > 0) ? (by_reg < y1_w) : (by_reg > y1_w));
        st.div_busy   = div_busy;
        st.ring_close = in_end_reg && ring_reg &&
                        ((in_x_reg != first_x_reg) || (in_y_reg != first_y_reg));
        st.cnt_zero   = (cnt_reg == '0);
        st.rd_last    = (CNT_W'(rd_idx_reg) == (cnt_reg - CNT_W'(1)));
    end

    assign out_x     = ram_rdata[2*COORD_W-1:COORD_W];
    assign out_y     = ram_rdata[COORD_W-1:0];
    assign run_last  = st.rd_last;
    assign truncated = over_reg;

endmodule

`default_nettype wire

// File: rtl/gls_ctrl.sv
`default_nettype none

module gls_ctrl
    import gls_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    input  wire status_t st,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   seg2_reg, seg2_next;
    logic   out_take;

    assign out_take = (state_reg == ST_OUT_SHOW) && !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        seg2_next  = seg2_reg;
        unique case (state_reg)
            ST_IDLE:       if (in_valid) state_next = ST_LOAD;
            ST_LOAD:
            begin
                seg2_next = 1'b0;
                if (st.seen0)      state_next = ST_IDLE;
                else if (st.seen1) state_next = ST_FIRST_EMIT;
                else if (st.pass)  state_next = ST_PASS_IN;
                else               state_next = ST_CELL_START;
            end
            ST_FIRST_EMIT: state_next = st.pass ? ST_PASS_IN : ST_CELL_START;
            ST_PASS_IN:    state_next = ST_PASS_RING;
            ST_PASS_RING:  state_next = st.ring_close ? ST_PASS_FIRST : ST_FINISH;
            ST_PASS_FIRST: state_next = ST_FINISH;
            ST_CELL_START: state_next = ST_CELL_WAIT;
            ST_CELL_WAIT:  if (!st.div_busy) state_next = ST_SEG_LOAD;
            ST_SEG_LOAD:   state_next = ST_BX_DIV;
            ST_BX_DIV:     state_next = st.zero_len ? ST_SEG_DONE : ST_BX_WAIT;
            ST_BX_WAIT:    if (!st.div_busy) state_next = ST_BX_MUL;
            ST_BX_MUL:     state_next = ST_BY_DIV;
            ST_BY_DIV:     state_next = ST_BY_WAIT;
            ST_BY_WAIT:    if (!st.div_busy) state_next = ST_BY_MUL;
            ST_BY_MUL:     state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (st.vx && st.vy)      state_next = ST_PX_MUL;
                else if (st.vx || st.vy) state_next = ST_N1_MUL;
                else                     state_next = ST_END_EMIT;
            end
            ST_PX_MUL:     state_next = ST_PY_MUL;
            ST_PY_MUL:     state_next = ST_CMP;
            ST_CMP:        state_next = ST_N1_MUL;
            ST_N1_MUL:     state_next = ST_N2_MUL;
            ST_N2_MUL:     state_next = ST_RND_DIV;
            ST_RND_DIV:    state_next = ST_RND_WAIT;
            ST_RND_WAIT:   if (!st.div_busy) state_next = ST_CROSS_EMIT;
            ST_CROSS_EMIT: state_next = ST_CHECK;
            ST_END_EMIT:   state_next = ST_SEG_DONE;
            ST_SEG_DONE:
            begin
                if (!seg2_reg && st.ring_close)
                begin
                    seg2_next  = 1'b1;
                    state_next = ST_SEG_LOAD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:     state_next = st.cnt_zero ? ST_IDLE : ST_OUT_READ;
            ST_OUT_READ:   state_next = ST_OUT_SHOW;
            ST_OUT_SHOW:
            begin
                if (out_take)
                begin
                    state_next = st.rd_last ? ST_IDLE : ST_OUT_READ;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        cmd          = '0;
        cmd.seg_sel  = seg2_reg ? SEG_IN_FIRST : SEG_PREV_IN;
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.latch_in = in_valid;
            end
            ST_LOAD:
            begin
                cmd.first_only = st.seen0;
                cmd.clr_cnt    = !st.seen0;
            end
            ST_FIRST_EMIT:
            begin
                cmd.emit_en  = 1'b1;
                cmd.emit_sel = EM_FIRST;
            end
            ST_PASS_IN:
            begin
                cmd.emit_en  = 1'b1;
                cmd.emit_sel = EM_INPUT;
            end
            ST_PASS_FIRST:
            begin
                cmd.emit_en  = 1'b1;
                cmd.emit_sel = EM_FIRST;
            end
            ST_CELL_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DV_CELL;
            end
            ST_CELL_WAIT:  cmd.cell_load = !st.div_busy;
            ST_SEG_LOAD:   cmd.seg_load  = 1'b1;
            ST_BX_DIV:
            begin
                cmd.div_start = !st.zero_len;
                cmd.div_sel   = DV_BX;
            end
            ST_BX_MUL:     cmd.mul_op = MU_BX;
            ST_BY_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DV_BY;
            end
            ST_BY_MUL:     cmd.mul_op = MU_BY;
            ST_CHECK:      cmd.take_single = !(st.vx && st.vy);
            ST_PX_MUL:     cmd.mul_op = MU_PX;
            ST_PY_MUL:     cmd.mul_op = MU_PY;
            ST_CMP:        cmd.take_cmp = 1'b1;
            ST_N1_MUL:     cmd.mul_op = MU_N1;
            ST_N2_MUL:     cmd.mul_op = MU_N2;
            ST_RND_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DV_RND;
            end
            ST_CROSS_EMIT:
            begin
                cmd.emit_en  = 1'b1;
                cmd.emit_sel = EM_CROSS;
                cmd.dedupe   = 1'b1;
                cmd.advance  = 1'b1;
            end
            ST_END_EMIT:
            begin
                cmd.emit_en  = 1'b1;
                cmd.emit_sel = EM_END;
                cmd.dedupe   = 1'b1;
            end
            ST_FINISH:     cmd.finish = 1'b1;
            ST_OUT_READ:   cmd.rd_en  = 1'b1;
            ST_OUT_SHOW:
            begin
                out_valid   = 1'b1;
                cmd.rd_next = out_take && !st.rd_last;
            end
            default:       cmd.rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seg2_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seg2_reg  <= seg2_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/grid_line_subdivider_core.sv
`default_nettype none

// Channel   Handshake            Payload
// ------    ---------            -------
// input     in_valid / in_stall  point_x, point_y, line_end
// output    out_valid/out_stall  out_x, out_y, run_last, truncated
// config    cfg_write            cfg_index, cfg_data (0: grid_divisions, 1: ring_mode)
//
// One point transaction at a time. A segment's setup runs two divides for the first grid
// lines, then each crossing runs a rounding divide, all on the shared 40-step divider;
// a subdividing step adds one more divide for the cell size. Each result is then read
// from the result buffer before it is shown.
// Reset is asynchronous, active low; results wait in place while out_stall is high.

module grid_line_subdivider_core
    import gls_pkg::*;
#(
    parameter int TILE_EXTENT = 8192,
    parameter int MAX_RUN     = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [COORD_W-1:0] point_x,
    input  wire logic signed [COORD_W-1:0] point_y,
    input  wire logic                      line_end,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed      [COORD_W-1:0] out_x,
    output logic signed      [COORD_W-1:0] out_y,
    output logic                           run_last,
    output logic                           truncated,
    input  wire logic                      cfg_write,
    input  wire logic                      cfg_index,
    input  wire logic        [CFG_W-1:0]   cfg_data
);

    cmd_t    cmd;
    status_t st;

    gls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    gls_datapath #(
        .TILE_EXTENT (TILE_EXTENT),
        .MAX_RUN     (MAX_RUN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .point_x   (point_x),
        .point_y   (point_y),
        .line_end  (line_end),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_x     (out_x),
        .out_y     (out_y),
        .run_last  (run_last),
        .truncated (truncated)
    );

endmodule

`default_nettype wire
